// ===== rtl/core/nrwd_pkg.sv =====
// Shared types and constants for the NVMe register write decoder.
package nrwd_pkg;

    localparam int OfsW = 12;
    localparam int DataW = 64;
    localparam int RegW = 32;

    // Register byte offsets.
    localparam logic [OfsW-1:0] OFS_MASK_SET = 12'h00c;
    localparam logic [OfsW-1:0] OFS_MASK_CLR = 12'h010;
    localparam logic [OfsW-1:0] OFS_CONFIG   = 12'h014;
    localparam logic [OfsW-1:0] OFS_ATTR     = 12'h024;
    localparam logic [OfsW-1:0] OFS_SQ_LO    = 12'h028;
    localparam logic [OfsW-1:0] OFS_SQ_HI    = 12'h02c;
    localparam logic [OfsW-1:0] OFS_CQ_LO    = 12'h030;
    localparam logic [OfsW-1:0] OFS_CQ_HI    = 12'h034;

    // Status bits and values.
    localparam logic [RegW-1:0] ST_READY     = 32'h0000_0001;
    localparam logic [RegW-1:0] ST_FATAL     = 32'h0000_0002;
    localparam logic [RegW-1:0] ST_SHUT_DONE = 32'h0000_0008;

    // Configuration field positions.
    localparam int CfgEnBit = 0;
    localparam int CfgShnLo = 14;
    localparam int CfgShnHi = 15;

    typedef struct packed {
        logic [OfsW-1:0]  reg_offset;
        logic [DataW-1:0] write_data;
        logic             start_ok;
    } req_t;

    typedef struct packed {
        logic [RegW-1:0]  intr_mask;
        logic [RegW-1:0]  ctrl_cfg;
        logic [RegW-1:0]  ctrl_status;
        logic [RegW-1:0]  queue_attr;
        logic [DataW-1:0] sq_base;
        logic [DataW-1:0] cq_base;
        logic             start_pulse;
        logic             clear_pulse;
    } rsp_t;

endpackage

// ===== rtl/core/nrwd_in_stage.sv =====
// Input request register of the NVMe register write decoder.
module nrwd_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nrwd_pkg::req_t s_req,
    input  logic          take,
    output logic          req_valid,
    output nrwd_pkg::req_t req
);

    logic           valid_reg;
    nrwd_pkg::req_t req_reg;

    // A new request enters whenever the held one is empty or leaves this cycle.
    assign s_ready   = !valid_reg || take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

// ===== rtl/core/nrwd_regfile.sv =====
// Controller register file with the write decode and update logic.
module nrwd_regfile (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           upd,
    input  nrwd_pkg::req_t req,
    output nrwd_pkg::rsp_t rsp_next
);

    logic [nrwd_pkg::RegW-1:0]  mask_reg;
    logic [nrwd_pkg::RegW-1:0]  cfg_reg;
    logic [nrwd_pkg::RegW-1:0]  status_reg;
    logic [nrwd_pkg::RegW-1:0]  attr_reg;
    logic [nrwd_pkg::DataW-1:0] sq_base_reg;
    logic [nrwd_pkg::DataW-1:0] cq_base_reg;

    logic [nrwd_pkg::RegW-1:0]  d32;
    logic [nrwd_pkg::DataW-1:0] hi_word;
    logic                       en_d;
    logic                       shn_d;

    assign d32     = req.write_data[nrwd_pkg::RegW-1:0];
    assign hi_word = {d32, {nrwd_pkg::RegW{1'b0}}};
    assign en_d    = d32[nrwd_pkg::CfgEnBit];
    assign shn_d   = |d32[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo];

    always_comb begin
        logic [nrwd_pkg::RegW-1:0] cfg_v;
        logic [nrwd_pkg::RegW-1:0] st_v;
        logic                      started;
        logic                      cleared;

        cfg_v   = cfg_reg;
        st_v    = status_reg;
        started = 1'b0;
        cleared = 1'b0;

        rsp_next.intr_mask  = mask_reg;
        rsp_next.queue_attr = attr_reg;
        rsp_next.sq_base    = sq_base_reg;
        rsp_next.cq_base    = cq_base_reg;

        case (req.reg_offset)
            nrwd_pkg::OFS_MASK_SET: begin
                rsp_next.intr_mask = mask_reg | d32;
            end
            nrwd_pkg::OFS_MASK_CLR: begin
                rsp_next.intr_mask = mask_reg & ~d32;
            end
            nrwd_pkg::OFS_CONFIG: begin
                // Each check sees the configuration as left by the checks before it.
                if (!en_d && !cfg_v[nrwd_pkg::CfgEnBit] && !shn_d
                    && !(|cfg_v[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo])) begin
                    cfg_v = d32;
                end
                if (en_d && !cfg_v[nrwd_pkg::CfgEnBit]) begin
                    cfg_v   = d32;
                    started = 1'b1;
                    st_v    = req.start_ok ? nrwd_pkg::ST_READY : nrwd_pkg::ST_FATAL;
                end else if (!en_d && cfg_v[nrwd_pkg::CfgEnBit]) begin
                    cleared = 1'b1;
                    st_v    = st_v & ~nrwd_pkg::ST_READY;
                end
                if (shn_d && !(|cfg_v[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo])) begin
                    cleared = 1'b1;
                    cfg_v   = d32;
                    st_v    = st_v | nrwd_pkg::ST_SHUT_DONE;
                end else if (!shn_d && (|cfg_v[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo])) begin
                    st_v  = st_v & ~nrwd_pkg::ST_SHUT_DONE;
                    cfg_v = d32;
                end
            end
            nrwd_pkg::OFS_ATTR: begin
                rsp_next.queue_attr = d32;
            end
            nrwd_pkg::OFS_SQ_LO: begin
                rsp_next.sq_base = req.write_data;
            end
            nrwd_pkg::OFS_SQ_HI: begin
                // The high half only ever sets bits.
                rsp_next.sq_base = sq_base_reg | hi_word;
            end
            nrwd_pkg::OFS_CQ_LO: begin
                rsp_next.cq_base = req.write_data;
            end
            nrwd_pkg::OFS_CQ_HI: begin
                rsp_next.cq_base = cq_base_reg | hi_word;
            end
            default: begin
            end
        endcase

        rsp_next.ctrl_cfg    = cfg_v;
        rsp_next.ctrl_status = st_v;
        rsp_next.start_pulse = started;
        rsp_next.clear_pulse = cleared;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            cfg_reg     <= '0;
            status_reg  <= '0;
            attr_reg    <= '0;
            sq_base_reg <= '0;
            cq_base_reg <= '0;
        end else if (upd) begin
            mask_reg    <= rsp_next.intr_mask;
            cfg_reg     <= rsp_next.ctrl_cfg;
            status_reg  <= rsp_next.ctrl_status;
            attr_reg    <= rsp_next.queue_attr;
            sq_base_reg <= rsp_next.sq_base;
            cq_base_reg <= rsp_next.cq_base;
        end
    end

endmodule

// ===== rtl/core/nrwd_out_stage.sv =====
// Result register of the NVMe register write decoder.
module nrwd_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    output logic           can_load,
    input  nrwd_pkg::rsp_t rsp_in,
    output logic           m_valid,
    input  logic           m_ready,
    output nrwd_pkg::rsp_t rsp_out
);

    logic           valid_reg;
    nrwd_pkg::rsp_t rsp_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign rsp_out  = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rsp_reg <= rsp_in;
        end
    end

endmodule

// ===== rtl/core/nvme_register_write_decoder.sv =====
// Top level of the NVMe controller register write decoder.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | reg_offset, write_data, start_ok
//  m_      | out       | m_valid / m_ready  | all registers, start and clear pulses
//
// A request is held in the input register; the decode and register update sit
// between that register and the result register, which drives m_valid, and
// one request per cycle is sustained while m_ready does not stall.
// aresetn is synchronous and clears the controller registers and both valids.
// A stall on m_ready holds the result and backs up into the input register.
module nvme_register_write_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_reg_offset,
    input  logic [63:0] s_write_data,
    input  logic        s_start_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_interrupt_mask,
    output logic [31:0] m_controller_config,
    output logic [31:0] m_controller_status,
    output logic [31:0] m_queue_attributes,
    output logic [63:0] m_submission_base,
    output logic [63:0] m_completion_base,
    output logic        m_start_pulse,
    output logic        m_clear_pulse
);

    nrwd_pkg::req_t s_req;
    nrwd_pkg::req_t req;
    nrwd_pkg::rsp_t rsp_next;
    nrwd_pkg::rsp_t rsp;
    logic           req_valid;
    logic           can_load;
    logic           take;

    assign s_req.reg_offset = s_reg_offset;
    assign s_req.write_data = s_write_data;
    assign s_req.start_ok   = s_start_ok;

    assign take = req_valid && can_load;

    nrwd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .take      (take),
        .req_valid (req_valid),
        .req       (req)
    );

    nrwd_regfile u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (take),
        .req      (req),
        .rsp_next (rsp_next)
    );

    nrwd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .can_load (can_load),
        .rsp_in   (rsp_next),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .rsp_out  (rsp)
    );

    assign m_interrupt_mask    = rsp.intr_mask;
    assign m_controller_config = rsp.ctrl_cfg;
    assign m_controller_status = rsp.ctrl_status;
    assign m_queue_attributes  = rsp.queue_attr;
    assign m_submission_base   = rsp.sq_base;
    assign m_completion_base   = rsp.cq_base;
    assign m_start_pulse       = rsp.start_pulse;
    assign m_clear_pulse       = rsp.clear_pulse;

endmodule

// ===== tb/sv/tb_nvme_register_write_decoder.sv =====
// Testbench for the NVMe controller register write decoder: directed table, random writes.
`timescale 1ns / 100ps

module tb_nvme_register_write_decoder;

    typedef struct {
        nrwd_pkg::req_t req;
        bit             typed;
        nrwd_pkg::rsp_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_reg_offset;
    logic [63:0] s_write_data;
    logic        s_start_ok;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_interrupt_mask;
    logic [31:0] m_controller_config;
    logic [31:0] m_controller_status;
    logic [31:0] m_queue_attributes;
    logic [63:0] m_submission_base;
    logic [63:0] m_completion_base;
    logic        m_start_pulse;
    logic        m_clear_pulse;

    // Shadow copy of the controller registers.
    logic [nrwd_pkg::RegW-1:0]  ctl_mask;
    logic [nrwd_pkg::RegW-1:0]  ctl_cfg;
    logic [nrwd_pkg::RegW-1:0]  ctl_status;
    logic [nrwd_pkg::RegW-1:0]  ctl_attr;
    logic [nrwd_pkg::DataW-1:0] ctl_sq;
    logic [nrwd_pkg::DataW-1:0] ctl_cq;

    nrwd_pkg::rsp_t expected_regs[$];
    stim_row_t      directed_rows[$];
    int             err_count;
    bit             steady_flow;

    nvme_register_write_decoder i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_reg_offset        (s_reg_offset),
        .s_write_data        (s_write_data),
        .s_start_ok          (s_start_ok),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_interrupt_mask    (m_interrupt_mask),
        .m_controller_config (m_controller_config),
        .m_controller_status (m_controller_status),
        .m_queue_attributes  (m_queue_attributes),
        .m_submission_base   (m_submission_base),
        .m_completion_base   (m_completion_base),
        .m_start_pulse       (m_start_pulse),
        .m_clear_pulse       (m_clear_pulse)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit cfg_enabled(input logic [nrwd_pkg::RegW-1:0] v);
        return v[nrwd_pkg::CfgEnBit];
    endfunction

    function automatic bit shutdown_req(input logic [nrwd_pkg::RegW-1:0] v);
        return |v[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo];
    endfunction

    // Applies one register write to the shadow registers and returns the report.
    function automatic nrwd_pkg::rsp_t apply_register_write(input nrwd_pkg::req_t r);
        nrwd_pkg::rsp_t            res;
        logic [nrwd_pkg::RegW-1:0] d32;
        bit                        en_d;
        bit                        shn_d;
        bit                        started;
        bit                        cleared;
        d32 = r.write_data[nrwd_pkg::RegW-1:0];
        en_d = cfg_enabled(d32);
        shn_d = shutdown_req(d32);
        started = 1'b0;
        cleared = 1'b0;
        case (r.reg_offset)
            nrwd_pkg::OFS_MASK_SET: ctl_mask = ctl_mask | d32;
            nrwd_pkg::OFS_MASK_CLR: ctl_mask = ctl_mask & ~d32;
            nrwd_pkg::OFS_CONFIG: begin
                // Each check sees the configuration as left by the checks above it.
                if (!en_d && !cfg_enabled(ctl_cfg) && !shn_d && !shutdown_req(ctl_cfg))
                    ctl_cfg = d32;
                if (en_d && !cfg_enabled(ctl_cfg)) begin
                    ctl_cfg = d32;
                    started = 1'b1;
                    ctl_status = r.start_ok ? nrwd_pkg::ST_READY : nrwd_pkg::ST_FATAL;
                end else if (!en_d && cfg_enabled(ctl_cfg)) begin
                    cleared = 1'b1;
                    ctl_status = ctl_status & ~nrwd_pkg::ST_READY;
                end
                if (shn_d && !shutdown_req(ctl_cfg)) begin
                    cleared = 1'b1;
                    ctl_cfg = d32;
                    ctl_status = ctl_status | nrwd_pkg::ST_SHUT_DONE;
                end else if (!shn_d && shutdown_req(ctl_cfg)) begin
                    ctl_status = ctl_status & ~nrwd_pkg::ST_SHUT_DONE;
                    ctl_cfg = d32;
                end
            end
            nrwd_pkg::OFS_ATTR:  ctl_attr = d32;
            nrwd_pkg::OFS_SQ_LO: ctl_sq = r.write_data;
            nrwd_pkg::OFS_SQ_HI: ctl_sq = ctl_sq | {d32, 32'h0};
            nrwd_pkg::OFS_CQ_LO: ctl_cq = r.write_data;
            nrwd_pkg::OFS_CQ_HI: ctl_cq = ctl_cq | {d32, 32'h0};
            default: ;
        endcase
        res.intr_mask = ctl_mask;
        res.ctrl_cfg = ctl_cfg;
        res.ctrl_status = ctl_status;
        res.queue_attr = ctl_attr;
        res.sq_base = ctl_sq;
        res.cq_base = ctl_cq;
        res.start_pulse = started;
        res.clear_pulse = cleared;
        return res;
    endfunction

    function automatic void add_row(input logic [nrwd_pkg::OfsW-1:0] ofs,
                                    input logic [nrwd_pkg::DataW-1:0] data,
                                    input logic ok, input bit typed,
                                    input nrwd_pkg::rsp_t want);
        stim_row_t row;
        row.req.reg_offset = ofs;
        row.req.write_data = data;
        row.req.start_ok = ok;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic nrwd_pkg::req_t random_request();
        logic [nrwd_pkg::OfsW-1:0] known[8];
        nrwd_pkg::req_t            r;
        int unsigned               sel;
        int unsigned               kind;
        known = '{nrwd_pkg::OFS_MASK_SET, nrwd_pkg::OFS_MASK_CLR, nrwd_pkg::OFS_CONFIG,
                  nrwd_pkg::OFS_ATTR, nrwd_pkg::OFS_SQ_LO, nrwd_pkg::OFS_SQ_HI,
                  nrwd_pkg::OFS_CQ_LO, nrwd_pkg::OFS_CQ_HI};
        sel = $urandom_range(0, 99);
        if (sel < 15)
            r.reg_offset = 12'($urandom_range(0, 4095));
        else if (sel < 45)
            r.reg_offset = nrwd_pkg::OFS_CONFIG;
        else
            r.reg_offset = known[3'($urandom_range(0, 7))];
        kind = $urandom_range(0, 9);
        if (kind == 0)
            r.write_data = '0;
        else if (kind == 1)
            r.write_data = '1;
        else
            r.write_data = {$urandom, $urandom};
        // Steer configuration writes so enable and shutdown both toggle often.
        if (r.reg_offset == nrwd_pkg::OFS_CONFIG && kind > 1) begin
            r.write_data[nrwd_pkg::CfgEnBit] = 1'($urandom_range(0, 1));
            r.write_data[nrwd_pkg::CfgShnHi:nrwd_pkg::CfgShnLo] =
                ($urandom_range(0, 1) != 0) ? 2'($urandom_range(1, 3)) : 2'd0;
        end
        r.start_ok = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic int draw_wait();
        return steady_flow ? 0 : int'($urandom_range(0, 13));
    endfunction

    task automatic drive_request(input nrwd_pkg::req_t r, input bit typed,
                                 input nrwd_pkg::rsp_t want);
        int             gap;
        nrwd_pkg::rsp_t predicted;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_reg_offset <= r.reg_offset;
        s_write_data <= r.write_data;
        s_start_ok <= r.start_ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_register_write(r);
        expected_regs.push_back(typed ? want : predicted);
    endtask

    task automatic check_result(input nrwd_pkg::rsp_t want);
        if (m_interrupt_mask !== want.intr_mask) begin
            $error("interrupt_mask: expected %h, got %h", want.intr_mask, m_interrupt_mask);
            err_count++;
        end
        if (m_controller_config !== want.ctrl_cfg) begin
            $error("controller_config: expected %h, got %h", want.ctrl_cfg, m_controller_config);
            err_count++;
        end
        if (m_controller_status !== want.ctrl_status) begin
            $error("controller_status: expected %h, got %h", want.ctrl_status,
                   m_controller_status);
            err_count++;
        end
        if (m_queue_attributes !== want.queue_attr) begin
            $error("queue_attributes: expected %h, got %h", want.queue_attr, m_queue_attributes);
            err_count++;
        end
        if (m_submission_base !== want.sq_base) begin
            $error("submission_base: expected %h, got %h", want.sq_base, m_submission_base);
            err_count++;
        end
        if (m_completion_base !== want.cq_base) begin
            $error("completion_base: expected %h, got %h", want.cq_base, m_completion_base);
            err_count++;
        end
        if (m_start_pulse !== want.start_pulse) begin
            $error("start_pulse: expected %b, got %b", want.start_pulse, m_start_pulse);
            err_count++;
        end
        if (m_clear_pulse !== want.clear_pulse) begin
            $error("clear_pulse: expected %b, got %b", want.clear_pulse, m_clear_pulse);
            err_count++;
        end
    endtask

    // Result side: random stalls on m_ready, every accepted result is checked.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_regs.size() == 0) begin
                $error("result with no request outstanding");
                err_count++;
            end else begin
                check_result(expected_regs.pop_front());
            end
        end
    end

    initial begin
        nrwd_pkg::rsp_t w;
        nrwd_pkg::req_t r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_reg_offset = '0;
        s_write_data = '0;
        s_start_ok = 1'b0;
        err_count = 0;
        steady_flow = 1'b0;
        ctl_mask = '0;
        ctl_cfg = '0;
        ctl_status = '0;
        ctl_attr = '0;
        ctl_sq = '0;
        ctl_cq = '0;

        // Directed table; values that follow plainly from reset are typed in.
        w = '0;
        add_row(12'hfff, '1, 1'b1, 1'b1, w);
        w.intr_mask = '1;
        add_row(nrwd_pkg::OFS_MASK_SET, '1, 1'b0, 1'b1, w);
        add_row(nrwd_pkg::OFS_MASK_CLR, 64'h0000_0000_ffff_0000, 1'b1, 1'b0, w);
        w = '0;
        add_row(nrwd_pkg::OFS_MASK_CLR, '1, 1'b1, 1'b1, w);
        w.queue_attr = '1;
        add_row(nrwd_pkg::OFS_ATTR, '1, 1'b0, 1'b1, w);
        // A failed start leaves the status at exactly fatal.
        w.ctrl_cfg = 32'h0000_0001;
        w.ctrl_status = nrwd_pkg::ST_FATAL;
        w.start_pulse = 1'b1;
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0000_0000_0000_0001, 1'b0, 1'b1, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0000_0000_0000_4000, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, '1, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'hffff_ffff_0000_0000, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0000_0000_1234_0ff0, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0000_0000_0000_c001, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CONFIG, 64'h0000_0000_0000_8000, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_SQ_LO, 64'h1234_5678_9abc_def0, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_SQ_HI, 64'hffff_ffff_0000_0001, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CQ_LO, '1, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_CQ_LO, 64'h0, 1'b1, 1'b0, w);
        add_row(nrwd_pkg::OFS_CQ_HI, 64'h0000_0000_ffff_ffff, 1'b0, 1'b0, w);
        add_row(nrwd_pkg::OFS_CQ_HI, 64'h0000_0000_0000_0000, 1'b1, 1'b0, w);
        add_row(12'h000, '1, 1'b1, 1'b0, w);
        add_row(12'h018, '1, 1'b0, 1'b0, w);
        add_row(12'h038, '1, 1'b1, 1'b0, w);
        add_row(12'h00d, '1, 1'b0, 1'b0, w);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < 550; n++) begin
            steady_flow = (n >= 100 && n < 160) || (n >= 400 && n < 450);
            if (n == 275) begin
                // Let the pipeline drain completely before resuming requests.
                s_valid <= 1'b0;
                while (expected_regs.size() != 0) @(posedge aclk);
            end
            r = random_request();
            drive_request(r, 1'b0, w);
        end
        s_valid <= 1'b0;
        steady_flow = 1'b0;

        while (expected_regs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("tb_nvme_register_write_decoder: clean");
        else
            $display("tb_nvme_register_write_decoder: errors");
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_nvme_register_write_decoder: errors");
        $finish;
    end

endmodule
